[rtl/core/fdpm_pkg.sv]
package fdpm_pkg;

   // Frame geometry and store
   localparam int FRAME_PIXELS = 32768;
   localparam int POS_W        = $clog2(FRAME_PIXELS);
   localparam int SIZE_W       = POS_W + 2;
   localparam int COLOR_W      = 24;
   localparam int CHAN_W       = 8;

   // Configuration registers
   localparam int WIDTH_W      = 9;
   localparam int HEIGHT_W     = 8;
   localparam int STEP_W       = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_STEP  = 2'd2;
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 9'd256;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 8'd128;
   localparam logic [STEP_W-1:0]   STEP_MAX   = 5'd16;

   // Result fields
   localparam int COL_W = 8;
   localparam int ROW_W = 7;

   // Palette scan
   localparam int PALETTE_SIZE = 32;
   localparam int IDX_W        = $clog2(PALETTE_SIZE);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PALETTE_SIZE - 1);
   localparam int DIST_W       = 9;
   localparam logic [DIST_W-1:0] DIST_BOUND = 9'd256;
   localparam int SQ_W         = 2 * CHAN_W;
   localparam int SUM_W        = SQ_W + 2;
   localparam int SQRT_PER_STAGE = 3;

   // Divider, instanced twice in the front
   localparam int DVD_W     = POS_W;
   localparam int DVS_W     = WIDTH_W;
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic [COLOR_W-1:0] PALETTE [PALETTE_SIZE] = '{
      24'h8E2121, 24'h2D2F8F, 24'h157788, 24'h373A3E,
      24'h5EA918, 24'hD5658F, 24'h080A0F, 24'h603C20,
      24'h495B24, 24'hFFFFFF, 24'hE06101, 24'h64209C,
      24'hF1AF15, 24'hA9309F, 24'h2489C7, 24'h7D7D73,
      24'h9E2B27, 24'h253193, 24'h267191, 24'h414141,
      24'h39BA2E, 24'hD98199, 24'h181414, 24'h56331C,
      24'h364B18, 24'hE4E4E4, 24'hEB7E36, 24'h7E34BF,
      24'hC2B51C, 24'hBE49C9, 24'hE4ECFD, 24'hA0A7A7
   };

   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [STEP_W-1:0]   step;
   } cfg_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] root;
   } sq_state_type;

   // Three digits of the bitwise integer square root, starting at digit first.
   function automatic sq_state_type sqrt_steps(sq_state_type st_in, int first);
      sq_state_type   st;
      logic [SUM_W:0] trial;
      logic [SUM_W-1:0] bitv;
      int k;
      st = st_in;
      for (k = 0; k < SQRT_PER_STAGE; k++) begin
         bitv  = SUM_W'(1) << (SUM_W - 2 - 2 * (first + k));
         trial = {1'b0, st.root} + {1'b0, bitv};
         if ({1'b0, st.rem} >= trial) begin
            st.rem  = st.rem - trial[SUM_W-1:0];
            st.root = (st.root >> 1) + bitv;
         end else begin
            st.root = st.root >> 1;
         end
      end
      return st;
   endfunction

endpackage

[rtl/core/frame_delta_palette_mapper.sv]
// Channel   Direction  Handshake            Payload
// request   in         req_push / req_full  req_red, req_green, req_blue
// response  out        rsp_empty / rsp_pop  rsp_palette_index, rsp_column, rsp_row,
//                                           rsp_no_match
// csr       in         csr_we (no wait)     csr_index, csr_wdata
//
// The front takes no new request until the last is skipped, dropped or queued;
// two 15-step dividers run once for a skipped or dropped one, twice for a response.
// The back scans the 32 palette entries one per cycle through a 5-stage pipeline;
// a 2-entry job queue lets the two overlap.
// Reset is synchronous; the previous-frame store is not cleared.
// The response register holds while rsp_pop is low; the back then waits, the front
// keeps going until the job queue fills.
module frame_delta_palette_mapper (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [fdpm_pkg::CHAN_W-1:0]        req_red,
   input  logic [fdpm_pkg::CHAN_W-1:0]        req_green,
   input  logic [fdpm_pkg::CHAN_W-1:0]        req_blue,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [fdpm_pkg::IDX_W-1:0]         rsp_palette_index,
   output logic [fdpm_pkg::COL_W-1:0]         rsp_column,
   output logic [fdpm_pkg::ROW_W-1:0]         rsp_row,
   output logic                               rsp_no_match,
   input  logic                               csr_we,
   input  logic [fdpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fdpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [fdpm_pkg::WIDTH_W-1:0]  width_ff;
   logic [fdpm_pkg::HEIGHT_W-1:0] height_ff;
   logic [fdpm_pkg::STEP_W-1:0]   step_ff;
   fdpm_pkg::cfg_type             cfg;

   fdpm_pkg::job_type             fq_in, fq_out;
   logic                          fq_push, fq_full, fq_pop, fq_empty;

   // Hold the raw register values; a write beyond the list changes nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fdpm_pkg::WIDTH_MAX;
         height_ff <= fdpm_pkg::HEIGHT_MAX;
         step_ff   <= fdpm_pkg::STEP_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            fdpm_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            fdpm_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[fdpm_pkg::HEIGHT_W-1:0];
            fdpm_pkg::CSR_SAMPLE_STEP:  step_ff   <= csr_wdata[fdpm_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp: zero acts as one, values above the limit act as the limit.
   always_comb begin
      cfg.width = width_ff;
      if (width_ff == '0) begin
         cfg.width = fdpm_pkg::WIDTH_W'(1);
      end else if (width_ff > fdpm_pkg::WIDTH_MAX) begin
         cfg.width = fdpm_pkg::WIDTH_MAX;
      end
      cfg.height = height_ff;
      if (height_ff == '0) begin
         cfg.height = fdpm_pkg::HEIGHT_W'(1);
      end else if (height_ff > fdpm_pkg::HEIGHT_MAX) begin
         cfg.height = fdpm_pkg::HEIGHT_MAX;
      end
      cfg.step = step_ff;
      if (step_ff == '0) begin
         cfg.step = fdpm_pkg::STEP_W'(1);
      end else if (step_ff > fdpm_pkg::STEP_MAX) begin
         cfg.step = fdpm_pkg::STEP_MAX;
      end
   end

   // Front: position, sampling, previous-frame compare, coordinates.
   fdpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .job_push  (fq_push),
      .job       (fq_in),
      .job_full  (fq_full)
   );

   // Short queue between front and back.
   fdpm_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_in),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_out),
      .empty     (fq_empty)
   );

   // Back: nearest palette entry and response register.
   fdpm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job               (fq_out),
      .job_empty         (fq_empty),
      .job_pop           (fq_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_palette_index (rsp_palette_index),
      .rsp_column        (rsp_column),
      .rsp_row           (rsp_row),
      .rsp_no_match      (rsp_no_match)
   );

endmodule

[rtl/core/fdpm_div.sv]
module fdpm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fdpm_pkg::div_req_type req,
   output fdpm_pkg::div_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [fdpm_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [fdpm_pkg::DVD_W-1:0]      quo_ff, quo_in;
   logic [fdpm_pkg::DVS_W-1:0]      rem_ff, rem_in;
   logic [fdpm_pkg::DVS_W-1:0]      dvs_ff, dvs_in;
   logic [fdpm_pkg::DVS_W:0]        rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[fdpm_pkg::DVD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         quo_in = {quo_ff[fdpm_pkg::DVD_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in    = fdpm_pkg::DVS_W'(rem_sh - {1'b0, dvs_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_sh[fdpm_pkg::DVS_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fdpm_pkg::DIV_CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

[rtl/core/fdpm_front.sv]
module fdpm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fdpm_pkg::cfg_type                    cfg,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [fdpm_pkg::CHAN_W-1:0]          req_red,
   input  logic [fdpm_pkg::CHAN_W-1:0]          req_green,
   input  logic [fdpm_pkg::CHAN_W-1:0]          req_blue,
   output logic                                 job_push,
   output fdpm_pkg::job_type                    job,
   input  logic                                 job_full
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_DIV1 = 3'd1;
   localparam logic [2:0] F_DIV2 = 3'd2;
   localparam logic [2:0] F_PUSH = 3'd3;

   logic [2:0]                      state_ff, state_in;
   logic [fdpm_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                            past_ff, past_in;
   logic [fdpm_pkg::POS_W-1:0]      cur_pos_ff;
   logic                            cur_past_ff;
   logic [fdpm_pkg::COLOR_W-1:0]    color_ff;
   logic [fdpm_pkg::COLOR_W-1:0]    rd_ff;
   logic [fdpm_pkg::COLOR_W-1:0]    store [fdpm_pkg::FRAME_PIXELS];

   logic                            accept;
   logic                            store_we;
   logic [fdpm_pkg::SIZE_W-1:0]     frame_size;
   logic [fdpm_pkg::SIZE_W-1:0]     pos_inc;
   fdpm_pkg::div_req_type           div_a_req, div_b_req;
   fdpm_pkg::div_rsp_type           div_a_rsp, div_b_rsp;

   fdpm_div u_div_a (.clock(clock), .reset(reset), .req(div_a_req), .rsp(div_a_rsp));
   fdpm_div u_div_b (.clock(clock), .reset(reset), .req(div_b_req), .rsp(div_b_rsp));

   assign req_full   = (state_ff != F_IDLE);
   assign accept     = req_push && !req_full;
   assign frame_size = fdpm_pkg::SIZE_W'(cfg.width) * fdpm_pkg::SIZE_W'(cfg.height);
   assign pos_inc    = fdpm_pkg::SIZE_W'(pos_ff) + 1'b1;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      past_in   = past_ff;
      store_we  = 1'b0;
      job_push  = 1'b0;
      div_a_req = '0;
      div_b_req = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               // advance the position now; the request keeps its own copy
               if (pos_inc >= frame_size) begin
                  pos_in  = '0;
                  past_in = 1'b1;
               end else begin
                  pos_in = pos_inc[fdpm_pkg::POS_W-1:0];
               end
               div_a_req.start    = 1'b1;
               div_a_req.dividend = pos_ff;
               div_a_req.divisor  = fdpm_pkg::DVS_W'(cfg.step);
               div_b_req.start    = 1'b1;
               div_b_req.dividend = pos_ff;
               div_b_req.divisor  = cfg.width;
               state_in = F_DIV1;
            end
         end
         F_DIV1: begin
            if (div_a_rsp.done) begin
               if (div_a_rsp.remainder != '0) begin
                  state_in = F_IDLE;
               end else begin
                  store_we = 1'b1;
                  if (cur_past_ff && (rd_ff == color_ff)) begin
                     state_in = F_IDLE;
                  end else begin
                     // column = x / step, row = y / step
                     div_a_req.start    = 1'b1;
                     div_a_req.dividend = fdpm_pkg::DVD_W'(div_b_rsp.remainder);
                     div_a_req.divisor  = fdpm_pkg::DVS_W'(cfg.step);
                     div_b_req.start    = 1'b1;
                     div_b_req.dividend = div_b_rsp.quotient;
                     div_b_req.divisor  = fdpm_pkg::DVS_W'(cfg.step);
                     state_in = F_DIV2;
                  end
               end
            end
         end
         F_DIV2: begin
            if (div_a_rsp.done) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!job_full) begin
               job_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign job.color  = color_ff;
   assign job.column = div_a_rsp.quotient[fdpm_pkg::COL_W-1:0];
   assign job.row    = div_b_rsp.quotient[fdpm_pkg::ROW_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= '0;
         past_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         past_ff  <= past_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_pos_ff  <= pos_ff;
         cur_past_ff <= past_ff;
         color_ff    <= {req_red, req_green, req_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[cur_pos_ff] <= color_ff;
      end
      if (accept) begin
         rd_ff <= store[pos_ff];
      end
   end

endmodule

[rtl/core/fdpm_job_queue.sv]
module fdpm_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fdpm_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output fdpm_pkg::job_type pop_data,
   output logic              empty
);

   localparam int DEPTH = 2;

   fdpm_pkg::job_type slots_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/fdpm_back.sv]
module fdpm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  fdpm_pkg::job_type               job,
   input  logic                            job_empty,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [fdpm_pkg::IDX_W-1:0]      rsp_palette_index,
   output logic [fdpm_pkg::COL_W-1:0]      rsp_column,
   output logic [fdpm_pkg::ROW_W-1:0]      rsp_row,
   output logic                            rsp_no_match
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RUN  = 2'd1;
   localparam logic [1:0] B_DONE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   fdpm_pkg::job_type              job_ff;
   logic                           issue_ff, issue_in;
   logic [fdpm_pkg::IDX_W-1:0]     iss_idx_ff, iss_idx_in;
   logic [fdpm_pkg::DIST_W-1:0]    best_ff, best_in;
   logic [fdpm_pkg::IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                           out_vld_ff, out_vld_in;
   logic                           load_out;

   // scan pipeline: squares, sum, three root stages
   logic                           a_vld_ff, b_vld_ff, c1_vld_ff, c2_vld_ff, c3_vld_ff;
   logic [fdpm_pkg::IDX_W-1:0]     a_idx_ff, b_idx_ff, c1_idx_ff, c2_idx_ff, c3_idx_ff;
   logic [fdpm_pkg::SQ_W-1:0]      a_sq_r_ff, a_sq_g_ff, a_sq_b_ff;
   logic [fdpm_pkg::SUM_W-1:0]     b_sum_ff;
   fdpm_pkg::sq_state_type         c1_ff, c2_ff, c3_ff, b_st;

   logic [fdpm_pkg::COLOR_W-1:0]   pal;
   logic [fdpm_pkg::CHAN_W-1:0]    dr, dg, db;
   logic [fdpm_pkg::DIST_W-1:0]    root_dist;

   function automatic logic [fdpm_pkg::CHAN_W-1:0] abs_diff(
      logic [fdpm_pkg::CHAN_W-1:0] a, logic [fdpm_pkg::CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign pal       = fdpm_pkg::PALETTE[iss_idx_ff];
   assign dr        = abs_diff(job_ff.color[23:16], pal[23:16]);
   assign dg        = abs_diff(job_ff.color[15:8],  pal[15:8]);
   assign db        = abs_diff(job_ff.color[7:0],   pal[7:0]);
   assign b_st      = '{rem: b_sum_ff, root: '0};
   assign root_dist = c3_ff.root[fdpm_pkg::DIST_W-1:0];

   assign load_out = (state_ff == B_DONE) && (!out_vld_ff || rsp_pop);

   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      iss_idx_in  = iss_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      job_pop     = 1'b0;
      out_vld_in  = out_vld_ff;
      if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop     = 1'b1;
               issue_in    = 1'b1;
               iss_idx_in  = '0;
               best_in     = fdpm_pkg::DIST_BOUND;
               best_idx_in = '0;
               state_in    = B_RUN;
            end
         end
         B_RUN: begin
            if (issue_ff) begin
               iss_idx_in = iss_idx_ff + 1'b1;
               if (iss_idx_ff == fdpm_pkg::IDX_LAST) begin
                  issue_in = 1'b0;
               end
            end
            // strictly smaller wins, so the lower index keeps a tie
            if (c3_vld_ff) begin
               if (root_dist < best_ff) begin
                  best_in     = root_dist;
                  best_idx_in = c3_idx_ff;
               end
               if (c3_idx_ff == fdpm_pkg::IDX_LAST) begin
                  state_in = B_DONE;
               end
            end
         end
         B_DONE: begin
            if (load_out) begin
               out_vld_in = 1'b1;
               state_in   = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         issue_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         c3_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         out_vld_ff <= out_vld_in;
         a_vld_ff   <= issue_ff;
         b_vld_ff   <= a_vld_ff;
         c1_vld_ff  <= b_vld_ff;
         c2_vld_ff  <= c1_vld_ff;
         c3_vld_ff  <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      iss_idx_ff  <= iss_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      if (job_pop) begin
         job_ff <= job;
      end
      a_idx_ff  <= iss_idx_ff;
      a_sq_r_ff <= dr * dr;
      a_sq_g_ff <= dg * dg;
      a_sq_b_ff <= db * db;
      b_idx_ff  <= a_idx_ff;
      b_sum_ff  <= fdpm_pkg::SUM_W'(a_sq_r_ff) + fdpm_pkg::SUM_W'(a_sq_g_ff)
                   + fdpm_pkg::SUM_W'(a_sq_b_ff);
      c1_idx_ff <= b_idx_ff;
      c1_ff     <= fdpm_pkg::sqrt_steps(b_st, 0);
      c2_idx_ff <= c1_idx_ff;
      c2_ff     <= fdpm_pkg::sqrt_steps(c1_ff, fdpm_pkg::SQRT_PER_STAGE);
      c3_idx_ff <= c2_idx_ff;
      c3_ff     <= fdpm_pkg::sqrt_steps(c2_ff, 2 * fdpm_pkg::SQRT_PER_STAGE);
      if (load_out) begin
         rsp_palette_index <= best_idx_ff;
         rsp_column        <= job_ff.column;
         rsp_row           <= job_ff.row;
         rsp_no_match      <= (best_ff == fdpm_pkg::DIST_BOUND);
      end
   end

   assign rsp_empty = !out_vld_ff;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import fdpm_pkg::*;

   // Run limits, in clock cycles
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned HOLD_OFF     = 600;
   localparam int unsigned MAX_GAP      = 24;
   // Count of positions written before the first wrap; later frames stay inside it
   localparam int unsigned SEEDED_SPAN  = 256;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [CHAN_W-1:0]     req_red;
   logic [CHAN_W-1:0]     req_green;
   logic [CHAN_W-1:0]     req_blue;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [IDX_W-1:0]      rsp_palette_index;
   logic [COL_W-1:0]      rsp_column;
   logic [ROW_W-1:0]      rsp_row;
   logic                  rsp_no_match;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   frame_delta_palette_mapper u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_palette_index (rsp_palette_index),
      .rsp_column        (rsp_column),
      .rsp_row           (rsp_row),
      .rsp_no_match      (rsp_no_match),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // One mapped pixel as it should leave the block
   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             no_match;
   } tile_type;

   // Palette held independently of the design package
   logic [COLOR_W-1:0] palette_rgb [PALETTE_SIZE] = '{
      24'h8E2121, 24'h2D2F8F, 24'h157788, 24'h373A3E,
      24'h5EA918, 24'hD5658F, 24'h080A0F, 24'h603C20,
      24'h495B24, 24'hFFFFFF, 24'hE06101, 24'h64209C,
      24'hF1AF15, 24'hA9309F, 24'h2489C7, 24'h7D7D73,
      24'h9E2B27, 24'h253193, 24'h267191, 24'h414141,
      24'h39BA2E, 24'hD98199, 24'h181414, 24'h56331C,
      24'h364B18, 24'hE4E4E4, 24'hEB7E36, 24'h7E34BF,
      24'hC2B51C, 24'hBE49C9, 24'hE4ECFD, 24'hA0A7A7
   };

   // Mirror of the block: registers, position counter and last-frame memory
   logic [WIDTH_W-1:0]  reg_width;
   logic [HEIGHT_W-1:0] reg_height;
   logic [STEP_W-1:0]   reg_step;
   int unsigned         cur_pos;
   bit                  wrapped_once;
   logic [COLOR_W-1:0]  prior_frame [FRAME_PIXELS];

   tile_type    awaited_tiles [$];
   tile_type    head_tile;
   int unsigned fault_count;
   int unsigned clock_count;
   int unsigned send_idle_pct;
   int unsigned take_idle_pct;
   int unsigned hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Register value as the block uses it: zero means one, clip at the top
   function automatic int unsigned clamp_field(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned root_floor(input int unsigned v);
      int unsigned r;
      int unsigned b;
      r = 0;
      for (b = 256; b != 0; b = b >> 1)
         if ((r + b) * (r + b) <= v) r = r + b;
      return r;
   endfunction

   // Advance the mirror by one pixel; return 1 when the pixel yields a tile
   function automatic bit map_pixel(input logic [CHAN_W-1:0] r, g, b, output tile_type tile);
      int unsigned w, h, s, size, p, best, d_root, k;
      int          dr, dg, db;
      logic [COLOR_W-1:0] color;
      bit          produced;
      w     = clamp_field(reg_width, WIDTH_MAX);
      h     = clamp_field(reg_height, HEIGHT_MAX);
      s     = clamp_field(reg_step, STEP_MAX);
      size  = w * h;
      if (size > FRAME_PIXELS) size = FRAME_PIXELS;
      p     = cur_pos;
      color = {r, g, b};
      produced = 1'b0;
      tile  = '0;
      if (p % s == 0) begin
         // Unchanged pixel since last frame: drop it, but still refresh memory
         if (!(wrapped_once && prior_frame[p % FRAME_PIXELS] == color)) begin
            best = 256;
            tile.no_match = 1'b1;
            for (k = 0; k < PALETTE_SIZE; k++) begin
               dr     = int'(r) - int'(palette_rgb[k][23:16]);
               dg     = int'(g) - int'(palette_rgb[k][15:8]);
               db     = int'(b) - int'(palette_rgb[k][7:0]);
               d_root = root_floor(dr * dr + dg * dg + db * db);
               // Strictly smaller only, so the lowest index keeps a tie
               if (d_root < best) begin
                  best          = d_root;
                  tile.index    = IDX_W'(k);
                  tile.no_match = 1'b0;
               end
            end
            tile.column = COL_W'((p % w) / s);
            tile.row    = ROW_W'((p / w) / s);
            produced    = 1'b1;
         end
         prior_frame[p % FRAME_PIXELS] = color;
      end
      // A position past a freshly shrunk frame also ends the frame here
      if (p + 1 >= size) begin
         cur_pos      = 0;
         wrapped_once = 1'b1;
      end else begin
         cur_pos = p + 1;
      end
      return produced;
   endfunction

   function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(24)) - 12;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   // Often a repeat of last frame at a sampled position once one exists, else palette-heavy colors
   function automatic logic [COLOR_W-1:0] next_color();
      int unsigned s, pick;
      logic [COLOR_W-1:0] base;
      s    = clamp_field(reg_step, STEP_MAX);
      pick = $urandom_range(99);
      if (wrapped_once && cur_pos % s == 0 && pick < 45) begin
         base = prior_frame[cur_pos % FRAME_PIXELS];
         // Near miss: one bit off the stored pixel must not be dropped
         if (pick < 8) base[$urandom_range(COLOR_W - 1)] ^= 1'b1;
         return base;
      end
      base = palette_rgb[$urandom_range(PALETTE_SIZE - 1)];
      case ($urandom_range(2))
         0: return base;
         1: return {jitter(base[23:16]), jitter(base[15:8]), jitter(base[7:0])};
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   // Random frame shape whose every position was written before the first wrap
   function automatic void pick_frame(output logic [CSR_DATA_W-1:0] w, h, s);
      do begin
         case ($urandom_range(9))
            0: w = '0;
            1: w = CSR_DATA_W'($urandom_range(511, 256));
            default: w = CSR_DATA_W'($urandom_range(32, 1));
         endcase
         case ($urandom_range(9))
            0: h = '0;
            1: h = CSR_DATA_W'($urandom_range(255, 128));
            default: h = CSR_DATA_W'($urandom_range(16, 1));
         endcase
         case ($urandom_range(9))
            0: s = '0;
            1: s = CSR_DATA_W'($urandom_range(31, 16));
            default: s = CSR_DATA_W'($urandom_range(8, 1));
         endcase
      end while (clamp_field(w, WIDTH_MAX) * clamp_field(h, HEIGHT_MAX) > SEEDED_SPAN);
   endfunction

   // Offer one pixel request; hold it until accepted, then log its tile if it makes one
   task send_pixel(input logic [COLOR_W-1:0] color);
      int unsigned gap;
      tile_type    tile;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push  <= 1'b1;
      req_red   <= color[23:16];
      req_green <= color[15:8];
      req_blue  <= color[7:0];
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (map_pixel(color[23:16], color[15:8], color[7:0], tile))
         awaited_tiles.insert(awaited_tiles.size(), tile);
   endtask

   // Drop the request line, drain every tile, then let dropped pixels finish
   task quiesce;
      @(negedge clock);
      req_push <= 1'b0;
      while (awaited_tiles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  reg_width  = value[WIDTH_W-1:0];
         CSR_FRAME_HEIGHT: reg_height = value[HEIGHT_W-1:0];
         CSR_SAMPLE_STEP:  reg_step   = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task configure(input logic [CSR_DATA_W-1:0] w, h, s);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_SAMPLE_STEP, s);
   endtask

   task set_idle(input int unsigned sender, input int unsigned receiver);
      send_idle_pct = sender;
      take_idle_pct = receiver;
   endtask

   task send_random(input int unsigned count);
      repeat (count) send_pixel(next_color());
   endtask

   // Cube corners, grays and exact palette hits at the reset geometry
   task test_palette_extremes;
      logic [COLOR_W-1:0] probes [20];
      int k;
      probes = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                 24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h7F7F7F,
                 24'h8E2121, 24'h2D2F8F, 24'h080A0F, 24'hE4ECFD, 24'hA0A7A7,
                 24'hE4E4E4, 24'hF1F1F1, 24'h555555, 24'hAAAAAA, 24'h010204};
      for (k = 0; k < 20; k++) send_pixel(probes[k]);
   endtask

   // Write the whole first row span so later small frames compare against real data;
   // the last column of a full-width row shows up here
   task test_first_row_fill;
      while (cur_pos < SEEDED_SPAN) send_pixel(next_color());
   endtask

   // Shrink the frame under the counter: the stray pixel ends the first frame,
   // its row overflows and is masked; then repeat frames to exercise dropping
   task test_frame_shrink_wrap;
      quiesce;
      configure(2, 32, 1);
      send_pixel(next_color());
      send_random(70);
   endtask

   // Zero and oversized register values, tallest and widest frames
   task test_register_limits;
      quiesce;
      configure(0, 0, 0);
      send_random(8);
      quiesce;
      configure(1, 200, 1);
      send_random(128);
      quiesce;
      configure(511, 1, 31);
      send_random(64);
      quiesce;
      configure(256, 0, 16);
      send_random(40);
   endtask

   task test_random_frames;
      logic [CSR_DATA_W-1:0] w, h, s;
      int unsigned regime, phase;
      for (regime = 0; regime < 3; regime++) begin
         case (regime)
            0: set_idle(14, 60);
            1: set_idle(60, 14);
            default: set_idle(0, 0);
         endcase
         for (phase = 0; phase < 5; phase++) begin
            quiesce;
            pick_frame(w, h, s);
            configure(w, h, s);
            send_random(16);
         end
      end
   endtask

   // Stall the result side for a long stretch while requests keep coming, so the
   // job queue fills and the block pushes back on its input
   task test_output_backpressure;
      logic [COLOR_W-1:0] color;
      quiesce;
      configure(16, 16, 1);
      set_idle(0, 0);
      hold_off_cycles = HOLD_OFF;
      repeat (60) begin
         color = COLOR_W'($urandom);
         if (color == prior_frame[cur_pos % FRAME_PIXELS]) color[0] = ~color[0];
         send_pixel(color);
      end
   endtask

   // Result side: pop at random, or hold off while the stall counter runs
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   task check_field(input string label, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fault_count++;
      end
   endtask

   // Compare each popped tile with the oldest one still awaited
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_tiles.size() == 0) begin
            $display("%0t: unexpected tile, expected none, actual index %0d column %0d row %0d",
                     $time, rsp_palette_index, rsp_column, rsp_row);
            fault_count++;
         end else begin
            head_tile = awaited_tiles.pop_front();
            check_field("palette_index", head_tile.index, rsp_palette_index);
            check_field("column", head_tile.column, rsp_column);
            check_field("row", head_tile.row, rsp_row);
            check_field("no_match", head_tile.no_match, rsp_no_match);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      clock_count++;
      if (clock_count >= CYCLE_LIMIT) begin
         $display("frame_delta_palette_mapper regression: fail");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      reg_width       = WIDTH_MAX;
      reg_height      = HEIGHT_MAX;
      reg_step        = STEP_W'(1);
      cur_pos         = 0;
      wrapped_once    = 1'b0;
      fault_count     = 0;
      clock_count     = 0;
      hold_off_cycles = 0;
      set_idle(14, 60);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_palette_extremes;
      test_first_row_fill;
      test_frame_shrink_wrap;
      test_register_limits;
      test_random_frames;
      test_output_backpressure;
      quiesce;

      if (fault_count == 0 && awaited_tiles.size() == 0) begin
         $display("frame_delta_palette_mapper regression: pass");
      end else begin
         $display("frame_delta_palette_mapper regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/fdpm_pkg.sv
rtl/core/fdpm_div.sv
rtl/core/fdpm_front.sv
rtl/core/fdpm_job_queue.sv
rtl/core/fdpm_back.sv
rtl/core/frame_delta_palette_mapper.sv
sim/testbench.sv
